// File: src/clpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clpg_pkg
// Shared types and constants for the clipped line pixel generator.
// ----------------------------------------------------------------------------
package clpg_pkg;

    // Width of the window size registers
    localparam int WIN_BITS = 12;

    // Configuration register index width
    localparam int CFG_IDX_BITS = 1;

    // Reset values of the window size registers
    localparam logic [WIN_BITS-1:0] WINDOW_WIDTH_RESET  = 12'd640;
    localparam logic [WIN_BITS-1:0] WINDOW_HEIGHT_RESET = 12'd480;

    // Item kind carried on the slave tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_WIDTH  = 1'b0,
        REG_WINDOW_HEIGHT = 1'b1
    } reg_idx_t;

    // Fill status of the command queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : clpg_pkg
`default_nettype wire

// File: src/clipped_line_pixel_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_line_pixel_generator_top
// Bresenham line rasteriser with window clipping.
//
//   Channel  | Port group | Carries
//   ---------+------------+---------------------------------------------------
//   input    | s_axis_*   | load (segment end points) or step transactions
//   output   | m_axis_*   | one pixel per step while a segment is active
//   config   | cfg_*      | window width and height writes
//
// One transaction is accepted per cycle while the queue is not full; a step's
// pixel is queued at the accepting edge, then registered into the output slot.
// The Bresenham update is a combinational add, sign test and conditional
// subtract, so one pixel leaves per clock while steps are queued and the output
// is not stalled. Reset clears all stepping state, leaving the block idle.
// A stalled output holds the back part; the two-entry queue accepts until full.
// ----------------------------------------------------------------------------
module clipped_line_pixel_generator_top
    import clpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  wire logic                     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // visible
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [WIN_BITS-1:0]      cfg_data
);

    localparam int C        = COORD_BITS;
    localparam int ENTRY_W  = 4*COORD_BITS + 3;
    localparam int OUT_W    = ((2*COORD_BITS+7)/8)*8;

    logic [WIN_BITS-1:0] win_w_reg;
    logic [WIN_BITS-1:0] win_h_reg;
    q_status_t           q_status;
    logic                push;
    logic                pop;
    logic [ENTRY_W-1:0]  push_entry;
    logic [ENTRY_W-1:0]  pop_entry;
    logic [C-1:0]        pixel_x;
    logic [C-1:0]        pixel_y;
    op_t                 operation;

    assign operation = op_t'(s_axis_tuser);

    // Window size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= WINDOW_WIDTH_RESET;
            win_h_reg <= WINDOW_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                REG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    clpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operation (operation),
        .x_start   (s_axis_tdata[C-1:0]),
        .y_start   (s_axis_tdata[2*C-1:C]),
        .x_end     (s_axis_tdata[3*C-1:2*C]),
        .y_end     (s_axis_tdata[4*C-1:3*C]),
        .q_status  (q_status),
        .push      (push),
        .entry     (push_entry)
    );

    clpg_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .status    (q_status)
    );

    clpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .entry         (pop_entry),
        .pop           (pop),
        .window_width  (win_w_reg),
        .window_height (win_h_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .visible       (m_axis_tuser),
        .last_pixel    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule : clipped_line_pixel_generator_top
`default_nettype wire

// File: src/clpg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clpg_queue
// Two-entry command queue between the front and back parts. Push and pop
// may happen in the same cycle.
// ----------------------------------------------------------------------------
module clpg_queue
    import clpg_pkg::*;
#(
    parameter int WIDTH = 51
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output q_status_t             status
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule : clpg_queue
`default_nettype wire

// File: src/clpg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clpg_front
// Accepts input transactions and classifies them. Loads get their extents
// and step directions worked out here before going into the queue.
// ----------------------------------------------------------------------------
module clpg_front
    import clpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire op_t                     operation,
    input  wire logic [COORD_BITS-1:0]   x_start,
    input  wire logic [COORD_BITS-1:0]   y_start,
    input  wire logic [COORD_BITS-1:0]   x_end,
    input  wire logic [COORD_BITS-1:0]   y_end,
    input  wire q_status_t               q_status,
    output logic                         push,
    // entry: op, x0, y0, |dx|, |dy|, x_neg, y_neg (lowest first)
    output logic [4*COORD_BITS+2:0]      entry
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_abs;
    logic [COORD_BITS:0]   dy_abs;
    logic                  x_neg;
    logic                  y_neg;

    // Signed extents and their magnitudes
    always_comb
    begin
        dx     = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy     = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        x_neg  = dx[COORD_BITS];
        y_neg  = dy[COORD_BITS];
        dx_abs = x_neg ? ((COORD_BITS+1)'(0) - dx) : dx;
        dy_abs = y_neg ? ((COORD_BITS+1)'(0) - dy) : dy;
    end

    // Handshake towards the queue
    assign in_ready = ~q_status.full;
    assign push     = in_valid & ~q_status.full;

    assign entry = {y_neg, x_neg,
                    dy_abs[COORD_BITS-1:0], dx_abs[COORD_BITS-1:0],
                    y_start, x_start, operation};

endmodule : clpg_front
`default_nettype wire

// File: src/clpg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clpg_back
// Bresenham stepping state. Takes one queued command per cycle while the
// output register is free and produces clipped pixels.
// ----------------------------------------------------------------------------
module clpg_back
    import clpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire q_status_t               q_status,
    input  wire logic [4*COORD_BITS+2:0] entry,
    output logic                         pop,
    input  wire logic [WIN_BITS-1:0]     window_width,
    input  wire logic [WIN_BITS-1:0]     window_height,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic                         visible,
    output logic                         last_pixel
);

    localparam int C   = COORD_BITS;
    localparam int E   = COORD_BITS + 3;
    localparam int CW  = (COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS;

    // Queue entry fields
    logic          e_op_raw;
    op_t           e_op;
    logic [C-1:0]  e_x0;
    logic [C-1:0]  e_y0;
    logic [C-1:0]  e_adx;
    logic [C-1:0]  e_ady;
    logic          e_xneg;
    logic          e_yneg;

    // Stepping state
    logic [C-1:0]  cur_x_reg,  cur_x_next;
    logic [C-1:0]  cur_y_reg,  cur_y_next;
    logic [E-1:0]  err_reg,    err_next;
    logic [C:0]    maj2_reg,   maj2_next;
    logic [C:0]    min2_reg,   min2_next;
    logic [C-1:0]  left_reg,   left_next;
    logic          xneg_reg,   xneg_next;
    logic          yneg_reg,   yneg_next;
    logic          xmaj_reg,   xmaj_next;

    // Output register
    logic          valid_reg,  valid_next;
    logic [C-1:0]  px_reg,     px_next;
    logic [C-1:0]  py_reg,     py_next;
    logic          vis_reg,    vis_next;
    logic          last_reg,   last_next;

    logic          l_xmaj;
    logic [C-1:0]  l_major;
    logic [C-1:0]  l_minor;
    logic [E-1:0]  err_sum;
    logic [E-1:0]  err_sub;
    logic [C-1:0]  x_stepped;
    logic [C-1:0]  y_stepped;
    logic          x_ok;
    logic          y_ok;
    logic          emit;

    assign {e_yneg, e_xneg, e_ady, e_adx, e_y0, e_x0, e_op_raw} = entry;
    assign e_op = op_t'(e_op_raw);

    // Take a command when there is one and the output slot is free
    assign pop  = ~q_status.empty & (~valid_reg | out_ready);
    assign emit = pop & (e_op == OP_STEP) & (left_reg != '0);

    // Load set-up: pick the major axis, y wins a tie
    always_comb
    begin
        l_xmaj  = (e_adx > e_ady);
        l_major = l_xmaj ? e_adx : e_ady;
        l_minor = l_xmaj ? e_ady : e_adx;
    end

    // One Bresenham step
    always_comb
    begin
        err_sum   = err_reg + E'(min2_reg);
        err_sub   = err_sum - E'(maj2_reg);
        x_stepped = xneg_reg ? (cur_x_reg - C'(1)) : (cur_x_reg + C'(1));
        y_stepped = yneg_reg ? (cur_y_reg - C'(1)) : (cur_y_reg + C'(1));
    end

    // Window clipping of the current point
    always_comb
    begin
        x_ok = ~cur_x_reg[C-1] && (CW'(cur_x_reg) < CW'(window_width));
        y_ok = ~cur_y_reg[C-1] && (CW'(cur_y_reg) < CW'(window_height));
    end

    // State update
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        maj2_next  = maj2_reg;
        min2_next  = min2_reg;
        left_next  = left_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        xmaj_next  = xmaj_reg;
        if (pop && (e_op == OP_LOAD))
        begin
            cur_x_next = e_x0;
            cur_y_next = e_y0;
            err_next   = E'(0) - E'(l_major);
            maj2_next  = {l_major, 1'b0};
            min2_next  = {l_minor, 1'b0};
            left_next  = l_major;
            xneg_next  = e_xneg;
            yneg_next  = e_yneg;
            xmaj_next  = l_xmaj;
        end
        else if (emit)
        begin
            left_next = left_reg - C'(1);
            err_next  = err_sum[E-1] ? err_sum : err_sub;
            if (xmaj_reg)
            begin
                cur_x_next = x_stepped;
                if (!err_sum[E-1])
                begin
                    cur_y_next = y_stepped;
                end
            end
            else
            begin
                cur_y_next = y_stepped;
                if (!err_sum[E-1])
                begin
                    cur_x_next = x_stepped;
                end
            end
        end
    end

    // Output register update
    always_comb
    begin
        valid_next = valid_reg & ~out_ready;
        px_next    = px_reg;
        py_next    = py_reg;
        vis_next   = vis_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            px_next    = cur_x_reg;
            py_next    = cur_y_reg;
            vis_next   = x_ok & y_ok;
            last_next  = (left_reg == C'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            err_reg   <= '0;
            maj2_reg  <= '0;
            min2_reg  <= '0;
            left_reg  <= '0;
            xneg_reg  <= 1'b0;
            yneg_reg  <= 1'b0;
            xmaj_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
            maj2_reg  <= maj2_next;
            min2_reg  <= min2_next;
            left_reg  <= left_next;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
            xmaj_reg  <= xmaj_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        vis_reg  <= vis_next;
        last_reg <= last_next;
    end

    assign out_valid  = valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign visible    = vis_reg;
    assign last_pixel = last_reg;

endmodule : clpg_back
`default_nettype wire
